// File: rtl/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants of the exponential decay evaluator.
// ----------------------------------------------------------------------------
package edf_pkg;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_START_POSITION = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PEAK_AMPLITUDE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DECAY_CONSTANT = 2'd2;

  // reset values of the registers
  localparam logic [31:0] RST_START_POSITION = 32'd0;
  localparam logic [31:0] RST_PEAK_AMPLITUDE = 32'd65536;
  localparam logic [31:0] RST_DECAY_CONSTANT = 32'd65536;

  // fixed point constants, Q30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

  // saturation limits as magnitudes
  localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

  // quotient width of the exponent argument: Q30 below 64
  localparam int unsigned QUO_W = 36;

  // series terms 2..13, divided through floor(2^32 / n)
  localparam int unsigned N_TERMS = 12;
  localparam logic [31:0] DIV_RECIP [0:N_TERMS-1] = '{
    32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
    32'd715827882,  32'd613566756,  32'd536870912,  32'd477218588,
    32'd429496729,  32'd390451572,  32'd357913941,  32'd330382099
  };

  typedef struct packed {
    logic signed [31:0] sample_x;
    logic               last_point;
  } edf_in_t;

  typedef struct packed {
    logic signed [31:0] model_value;
    logic               overflow_flag;
    logic               bad_tau_flag;
    logic               last_out;
  } edf_out_t;

  // decoded configuration
  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] amag;
    logic [31:0] tmag;
    logic        amp_neg;
    logic        tau_neg;
    logic        tau_zero;
    logic        amp_zero;
  } edf_cfg_t;

  // per item control that rides along the pipeline
  typedef struct packed {
    logic last;
    logic done;
    logic ovf;
    logic bad;
    logic tneg;
  } edf_side_t;

endpackage

// File: rtl/edf_front.sv
// ----------------------------------------------------------------------------
// edf_front
// Forms |start_position - x|, the sign of the argument and the early cases.
// ----------------------------------------------------------------------------
module edf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  edf_pkg::edf_in_t  in_data,
  input  edf_pkg::edf_cfg_t cfg,
  output logic              vld_o,
  output edf_pkg::edf_side_t side_o,
  output logic [31:0]       nmag_o
);
  import edf_pkg::*;

  logic [32:0] num;
  logic [32:0] num_abs;
  logic [37:0] lim;
  logic        big;
  edf_side_t   side_nxt;
  logic        vld_r;
  edf_side_t   side_r;
  logic [31:0] nmag_r;

  // difference and range check against 64 * |tau|
  always_comb begin
    num      = {cfg.pos[31], cfg.pos} - {in_data.sample_x[31], in_data.sample_x};
    num_abs  = num[32] ? (33'd0 - num) : num;
    lim      = {cfg.tmag, 6'd0};
    big      = {6'd0, num_abs[31:0]} >= lim;
    side_nxt.last = in_data.last_point;
    side_nxt.tneg = num[32] ^ cfg.tau_neg;
    side_nxt.bad  = cfg.tau_zero;
    side_nxt.done = cfg.tau_zero | cfg.amp_zero | big;
    side_nxt.ovf  = !cfg.tau_zero && !cfg.amp_zero && big && !side_nxt.tneg &&
                    (num_abs[31:0] != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= side_nxt;
      nmag_r <= num_abs[31:0];
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign nmag_o = nmag_r;

endmodule

// File: rtl/edf_div.sv
// ----------------------------------------------------------------------------
// edf_div
// Pipelined restoring divider: (nmag << 30) / tmag, one quotient bit a stage.
// ----------------------------------------------------------------------------
module edf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [31:0]               tmag,
  input  logic                      vld_i,
  input  edf_pkg::edf_side_t        side_i,
  input  logic [31:0]               nmag_i,
  output logic                      vld_o,
  output edf_pkg::edf_side_t        side_o,
  output logic [edf_pkg::QUO_W-1:0] quo_o
);
  import edf_pkg::*;

  logic [30:0]      rem_r  [0:QUO_W-1];
  logic [QUO_W-1:0] quo_r  [0:QUO_W-1];
  logic [5:0]       nlo_r  [0:QUO_W-1];
  edf_side_t        side_r [0:QUO_W-1];
  logic             vld_r  [0:QUO_W-1];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [30:0]      rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [5:0]       nlo_in;
    edf_side_t        side_in;
    logic             vld_in;
    logic [31:0]      rsh;
    logic             ge;
    logic [31:0]      rem_nxt;

    // stage inputs: first stage takes the dividend top bits
    if (j == 0) begin : g_first
      assign rem_in  = {5'd0, nmag_i[31:6]};
      assign quo_in  = '0;
      assign nlo_in  = nmag_i[5:0];
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign quo_in  = quo_r[j-1];
      assign nlo_in  = nlo_r[j-1];
      assign side_in = side_r[j-1];
      assign vld_in  = vld_r[j-1];
    end

    // shift in the next dividend bit, trial subtract
    always_comb begin
      rsh     = {rem_in, nlo_in[5]};
      ge      = rsh >= tmag;
      rem_nxt = ge ? (rsh - tmag) : rsh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j]  <= rem_nxt[30:0];
        quo_r[j]  <= {quo_in[QUO_W-2:0], ge};
        nlo_r[j]  <= {nlo_in[4:0], 1'b0};
        side_r[j] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[QUO_W-1];
  assign side_o = side_r[QUO_W-1];
  assign quo_o  = quo_r[QUO_W-1];

endmodule

// File: rtl/edf_pow2.sv
// ----------------------------------------------------------------------------
// edf_pow2
// Scales the argument by log2(e), splits it into integer and fraction, and
// evaluates 2^f as a pipelined Taylor series of exp(f * ln2).
// ----------------------------------------------------------------------------
module edf_pow2 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      vld_i,
  input  edf_pkg::edf_side_t        side_i,
  input  logic [edf_pkg::QUO_W-1:0] quo_i,
  output logic                      vld_o,
  output edf_pkg::edf_side_t        side_o,
  output logic signed [8:0]         shift_o,
  output logic [30:0]               sum_o
);
  import edf_pkg::*;

  // log2(e) products
  logic [50:0]        pa_r;
  logic [46:0]        pb_r;
  edf_side_t          side1_r;
  logic               vld1_r;
  // range reduction
  logic [51:0]        usum;
  logic [37:0]        umag;
  logic [6:0]         ki;
  logic [29:0]        frac;
  logic signed [8:0]  k_nxt;
  logic [29:0]        f_nxt;
  logic [29:0]        f_r;
  logic signed [8:0]  s2_r;
  edf_side_t          side2_r;
  logic               vld2_r;
  // y = f * ln2
  logic [59:0]        yprod;
  logic [29:0]        y_r;
  logic signed [8:0]  s3_r;
  edf_side_t          side3_r;
  logic               vld3_r;

  // series stages: A multiply by y, B multiply by reciprocal, C correct and add
  logic [59:0]        a_prod_r [0:N_TERMS-1];
  logic [30:0]        a_sum_r  [0:N_TERMS-1];
  logic [29:0]        a_y_r    [0:N_TERMS-1];
  logic signed [8:0]  a_s_r    [0:N_TERMS-1];
  edf_side_t          a_side_r [0:N_TERMS-1];
  logic               a_vld_r  [0:N_TERMS-1];
  logic [61:0]        b_m_r    [0:N_TERMS-1];
  logic [29:0]        b_v_r    [0:N_TERMS-1];
  logic [30:0]        b_sum_r  [0:N_TERMS-1];
  logic [29:0]        b_y_r    [0:N_TERMS-1];
  logic signed [8:0]  b_s_r    [0:N_TERMS-1];
  edf_side_t          b_side_r [0:N_TERMS-1];
  logic               b_vld_r  [0:N_TERMS-1];
  logic [29:0]        c_term_r [0:N_TERMS-1];
  logic [30:0]        c_sum_r  [0:N_TERMS-1];
  logic [29:0]        c_y_r    [0:N_TERMS-1];
  logic signed [8:0]  c_s_r    [0:N_TERMS-1];
  edf_side_t          c_side_r [0:N_TERMS-1];
  logic               c_vld_r  [0:N_TERMS-1];

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // split k and f, folding the sign of the argument
  always_comb begin
    usum  = {1'b0, pa_r} + {21'd0, pb_r[46:16]};
    umag  = usum[51:14];
    ki    = umag[36:30];
    frac  = umag[29:0];
    if (!side1_r.tneg) begin
      k_nxt = $signed({2'b00, ki});
      f_nxt = frac;
    end else if (frac == 30'd0) begin
      k_nxt = -$signed({2'b00, ki});
      f_nxt = 30'd0;
    end else begin
      k_nxt = -$signed({2'b00, ki}) - 9'sd1;
      f_nxt = 30'(Q30_ONE - {1'b0, frac});
    end
  end

  assign yprod = 60'(f_r) * 60'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r    <= 51'(quo_i[QUO_W-1:16]) * 51'(LOG2E_Q30);
      pb_r    <= 47'(quo_i[15:0]) * 47'(LOG2E_Q30);
      side1_r <= side_i;
      f_r     <= f_nxt;
      s2_r    <= k_nxt - 9'sd30;
      side2_r <= side1_r;
      y_r     <= yprod[59:30];
      s3_r    <= s2_r;
      side3_r <= side2_r;
    end
  end

  for (genvar g = 0; g < N_TERMS; g++) begin : g_term
    localparam logic [33:0] DIVISOR = 34'(g + 2);
    logic [29:0]       term_in;
    logic [30:0]       sum_in;
    logic [29:0]       y_in;
    logic signed [8:0] s_in;
    edf_side_t         side_in;
    logic              vld_in;
    logic [29:0]       v;
    logic [29:0]       q0;
    logic [33:0]       rem;
    logic [29:0]       q;

    // first term of the series is y itself
    if (g == 0) begin : g_first
      assign term_in = y_r;
      assign sum_in  = Q30_ONE + {1'b0, y_r};
      assign y_in    = y_r;
      assign s_in    = s3_r;
      assign side_in = side3_r;
      assign vld_in  = vld3_r;
    end else begin : g_next
      assign term_in = c_term_r[g-1];
      assign sum_in  = c_sum_r[g-1];
      assign y_in    = c_y_r[g-1];
      assign s_in    = c_s_r[g-1];
      assign side_in = c_side_r[g-1];
      assign vld_in  = c_vld_r[g-1];
    end

    // quotient estimate is exact or one low
    always_comb begin
      v   = a_prod_r[g][59:30];
      q0  = b_m_r[g][61:32];
      rem = {4'd0, b_v_r[g]} - (34'(q0) * DIVISOR);
      q   = (rem >= DIVISOR) ? (q0 + 30'd1) : q0;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r[g] <= 1'b0;
        b_vld_r[g] <= 1'b0;
        c_vld_r[g] <= 1'b0;
      end else if (adv) begin
        a_vld_r[g] <= vld_in;
        b_vld_r[g] <= a_vld_r[g];
        c_vld_r[g] <= b_vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_prod_r[g] <= 60'(term_in) * 60'(y_in);
        a_sum_r[g]  <= sum_in;
        a_y_r[g]    <= y_in;
        a_s_r[g]    <= s_in;
        a_side_r[g] <= side_in;
        b_m_r[g]    <= 62'(v) * 62'(DIV_RECIP[g]);
        b_v_r[g]    <= v;
        b_sum_r[g]  <= a_sum_r[g];
        b_y_r[g]    <= a_y_r[g];
        b_s_r[g]    <= a_s_r[g];
        b_side_r[g] <= a_side_r[g];
        c_term_r[g] <= q;
        c_sum_r[g]  <= b_sum_r[g] + {1'b0, q};
        c_y_r[g]    <= b_y_r[g];
        c_s_r[g]    <= b_s_r[g];
        c_side_r[g] <= b_side_r[g];
      end
    end
  end

  assign vld_o   = c_vld_r[N_TERMS-1];
  assign side_o  = c_side_r[N_TERMS-1];
  assign shift_o = c_s_r[N_TERMS-1];
  assign sum_o   = c_sum_r[N_TERMS-1];

endmodule

// File: rtl/edf_scale.sv
// ----------------------------------------------------------------------------
// edf_scale
// Multiplies by |amplitude|, applies 2^(k-30) with rounding, saturates and
// restores the sign of the amplitude.
// ----------------------------------------------------------------------------
module edf_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  edf_pkg::edf_cfg_t  cfg,
  input  logic               vld_i,
  input  edf_pkg::edf_side_t side_i,
  input  logic signed [8:0]  shift_i,
  input  logic [30:0]        sum_i,
  output logic               vld_o,
  output edf_pkg::edf_out_t  data_o
);
  import edf_pkg::*;

  logic [62:0]       p_r;
  logic signed [8:0] s_r;
  edf_side_t         side1_r;
  logic              vld1_r;
  logic [8:0]        nsh;
  logic [63:0]       val_nxt;
  logic              sat_nxt;
  logic              zero_nxt;
  logic [63:0]       val_r;
  logic              sat_r;
  logic              zero_r;
  logic              rnd_r;
  edf_side_t         side2_r;
  logic              vld2_r;
  logic [63:0]       limit;
  logic [63:0]       mv;
  logic [63:0]       mag;
  logic              ovf;
  edf_out_t          out_nxt;
  edf_out_t          out_r;
  logic              vld3_r;

  // left shift by 0 or 1, or right shift by n-1 ahead of the rounding step
  always_comb begin
    nsh      = 9'd0 - s_r;
    sat_nxt  = 1'b0;
    zero_nxt = 1'b0;
    val_nxt  = {1'b0, p_r};
    if (s_r >= 9'sd0) begin
      sat_nxt = s_r > 9'sd1;
      if (s_r == 9'sd1) begin
        val_nxt = {p_r, 1'b0};
      end
    end else begin
      zero_nxt = nsh >= 9'd63;
      val_nxt  = {1'b0, p_r} >> 6'(nsh - 9'd1);
    end
  end

  // round half away, saturate and sign
  always_comb begin
    limit = cfg.amp_neg ? NEG_LIMIT : POS_LIMIT;
    mv    = rnd_r ? ((val_r + 64'd1) >> 1) : val_r;
    ovf   = 1'b0;
    if (side2_r.done) begin
      ovf = side2_r.ovf;
      mag = side2_r.ovf ? limit : 64'd0;
    end else if (sat_r) begin
      ovf = 1'b1;
      mag = limit;
    end else if (zero_r) begin
      mag = 64'd0;
    end else if (mv > limit) begin
      ovf = 1'b1;
      mag = limit;
    end else begin
      mag = mv;
    end
    out_nxt.model_value   = cfg.amp_neg ? (32'd0 - mag[31:0]) : mag[31:0];
    out_nxt.overflow_flag = ovf;
    out_nxt.bad_tau_flag  = side2_r.bad;
    out_nxt.last_out      = side2_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r     <= 63'(cfg.amag) * 63'(sum_i);
      s_r     <= shift_i;
      side1_r <= side_i;
      val_r   <= val_nxt;
      sat_r   <= sat_nxt;
      zero_r  <= zero_nxt;
      rnd_r   <= s_r < 9'sd0;
      side2_r <= side1_r;
      out_r   <= out_nxt;
    end
  end

  assign vld_o  = vld3_r;
  assign data_o = out_r;

endmodule

// File: rtl/exponential_decay_evaluator.sv
// ----------------------------------------------------------------------------
// exponential_decay_evaluator
// Streams amplitude * exp(-(x - position) / tau) in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one sample x and a
//   last-point marker per transaction; out_valid/out_stall/out_data returns
//   one result per transaction, in order, with overflow and bad-tau flags.
//   Registers start_position, peak_amplitude and decay_constant are written
//   through cfg_we/cfg_addr/cfg_wdata while no transaction is in flight.
// Throughput: one transaction per cycle, sustained while results are not stalled.
// Stages: one for the difference, 36 for the divider (one quotient bit each),
//   three for the log2(e) scaling, 36 for the twelve series terms, three for
//   the final multiply, shift and saturation.
// Reset: synchronous on rst_n low; the pipeline empties and the registers
//   return to position 0, amplitude 1.0, tau 1.0.
// Stall: a stalled result stays on out_data; the next one moves into a skid
//   register, and in_stall rises while that register is full so the whole
//   pipeline holds without losing or repeating a transaction.
// ----------------------------------------------------------------------------
module exponential_decay_evaluator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  edf_pkg::edf_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output edf_pkg::edf_out_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [edf_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [31:0]                          cfg_wdata
);
  import edf_pkg::*;

  logic [31:0]       pos_r;
  logic [31:0]       amp_r;
  logic [31:0]       tau_r;
  edf_cfg_t          cfg;
  logic              adv;
  logic              fr_vld;
  edf_side_t         fr_side;
  logic [31:0]       fr_nmag;
  logic              dv_vld;
  edf_side_t         dv_side;
  logic [QUO_W-1:0]  dv_quo;
  logic              pw_vld;
  edf_side_t         pw_side;
  logic signed [8:0] pw_shift;
  logic [30:0]       pw_sum;
  logic              pipe_vld;
  edf_out_t          pipe_data;
  logic              out_vld_r;
  logic              out_vld_nxt;
  edf_out_t          out_data_r;
  edf_out_t          out_data_nxt;
  logic              skid_vld_r;
  logic              skid_vld_nxt;
  edf_out_t          skid_data_r;
  edf_out_t          skid_data_nxt;
  logic              take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= RST_START_POSITION;
      amp_r <= RST_PEAK_AMPLITUDE;
      tau_r <= RST_DECAY_CONSTANT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_POSITION: pos_r <= cfg_wdata;
        REG_PEAK_AMPLITUDE: amp_r <= cfg_wdata;
        REG_DECAY_CONSTANT: tau_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // decoded magnitudes and signs
  always_comb begin
    cfg.pos      = pos_r;
    cfg.amag     = amp_r[31] ? (32'd0 - amp_r) : amp_r;
    cfg.tmag     = tau_r[31] ? (32'd0 - tau_r) : tau_r;
    cfg.amp_neg  = amp_r[31];
    cfg.tau_neg  = tau_r[31];
    cfg.tau_zero = tau_r == 32'd0;
    cfg.amp_zero = amp_r == 32'd0;
  end

  // pipeline moves whenever the skid register is free
  assign adv      = !skid_vld_r;
  assign in_stall = skid_vld_r;

  edf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid && !in_stall),
    .in_data (in_data),
    .cfg     (cfg),
    .vld_o   (fr_vld),
    .side_o  (fr_side),
    .nmag_o  (fr_nmag)
  );

  edf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .tmag   (cfg.tmag),
    .vld_i  (fr_vld),
    .side_i (fr_side),
    .nmag_i (fr_nmag),
    .vld_o  (dv_vld),
    .side_o (dv_side),
    .quo_o  (dv_quo)
  );

  edf_pow2 u_pow2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .vld_i   (dv_vld),
    .side_i  (dv_side),
    .quo_i   (dv_quo),
    .vld_o   (pw_vld),
    .side_o  (pw_side),
    .shift_o (pw_shift),
    .sum_o   (pw_sum)
  );

  edf_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cfg     (cfg),
    .vld_i   (pw_vld),
    .side_i  (pw_side),
    .shift_i (pw_shift),
    .sum_i   (pw_sum),
    .vld_o   (pipe_vld),
    .data_o  (pipe_data)
  );

  // output register with skid stage
  always_comb begin
    take          = !out_vld_r || !out_stall;
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    if (take) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = pipe_vld;
        out_data_nxt = pipe_data;
      end
    end else if (pipe_vld && adv) begin
      skid_vld_nxt  = 1'b1;
      skid_data_nxt = pipe_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // skid register only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register full while output register empty");

  // zero tau forces a plain zero result
  a_bad_tau_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.bad_tau_flag) |->
      (out_data_r.model_value == 32'sd0 && !out_data_r.overflow_flag))
    else $error("bad tau result not zero");

  // saturated results sit on a range limit
  a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.overflow_flag) |->
      (out_data_r.model_value == 32'h7FFF_FFFF ||
       out_data_r.model_value == 32'h8000_0000))
    else $error("overflow flag without saturated value");
`endif

endmodule

// File: dv/exponential_decay_evaluator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exponential_decay_evaluator_test
// Streams samples through the decay evaluator under random valid gaps and
// result stalls, across several register settings, and checks every result
// against a bit-accurate fixed point predictor.
// ----------------------------------------------------------------------------
module exponential_decay_evaluator_test;
  import edf_pkg::*;

  localparam int PIPE_LAT   = 79;
  localparam int IDLE_LIMIT = 20000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  edf_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  edf_out_t out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_START_POSITION;
  logic [31:0]           cfg_wdata = '0;

  // predictor copy of the registers
  logic [31:0] pred_pos, pred_amp, pred_tau;

  edf_in_t  pending_samples[$];
  edf_out_t expected_values[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  // input transaction taken at the last rising edge
  logic in_taken = 1'b0;

  exponential_decay_evaluator dut (.*);

  always #2 clk = ~clk;

  // 2^f with f in Q30, Taylor series of exp(f*ln2)
  function automatic logic [63:0] pow2_fraction(logic [63:0] f);
    logic [63:0] y, sum, term;
    y = (f * 64'(LN2_Q30)) >> 30;
    sum = 64'h4000_0000;
    term = 64'h4000_0000;
    for (int n = 1; n <= 13; n++) begin
      term = ((term * y) >> 30) / n;
      sum += term;
    end
    return sum;
  endfunction

  function automatic edf_out_t decay_value(edf_in_t s);
    edf_out_t r;
    longint x, pos, amp, tau, num;
    logic [63:0] amag, lim, mag, nmag, tmag, t, umag, f, p;
    logic t_neg, ovf, bad;
    int k, sh;
    x = longint'(s.sample_x);
    pos = longint'(signed'(pred_pos));
    amp = longint'(signed'(pred_amp));
    tau = longint'(signed'(pred_tau));
    amag = amp < 0 ? -amp : amp;
    lim = amp < 0 ? NEG_LIMIT : POS_LIMIT;
    mag = 0; ovf = 0; bad = 0;
    if (tau == 0) begin
      bad = 1;
    end else if (amag != 0) begin
      num = pos - x;
      nmag = num < 0 ? -num : num;
      tmag = tau < 0 ? -tau : tau;
      t_neg = (num < 0) != (tau < 0);
      if (nmag >= 64 * tmag) begin
        if (!t_neg && nmag != 0) begin
          ovf = 1; mag = lim;
        end
      end else begin
        t = (nmag << 30) / tmag;
        umag = (((t >> 16) * 64'(LOG2E_Q30))
                + (((t & 64'hFFFF) * 64'(LOG2E_Q30)) >> 16)) >> 14;
        if (!t_neg) begin
          k = int'(umag >> 30); f = umag & 64'h3FFF_FFFF;
        end else if ((umag & 64'h3FFF_FFFF) == 0) begin
          k = -int'(umag >> 30); f = 0;
        end else begin
          k = -int'(umag >> 30) - 1; f = 64'h4000_0000 - (umag & 64'h3FFF_FFFF);
        end
        p = amag * pow2_fraction(f);
        sh = k - 30;
        if (sh >= 0) begin
          if (sh >= 32 || p > (lim >> sh)) begin
            ovf = 1; mag = lim;
          end else begin
            mag = p << sh;
          end
        end else begin
          if (-sh >= 63) mag = 0;
          else mag = (p + (64'd1 << (-sh - 1))) >> (-sh);
          if (mag > lim) begin
            ovf = 1; mag = lim;
          end
        end
      end
    end
    r.model_value = amp < 0 ? 32'(-mag) : mag[31:0];
    r.overflow_flag = ovf;
    r.bad_tau_flag = bad;
    r.last_out = s.last_point;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_POSITION: pred_pos = val;
      REG_PEAK_AMPLITUDE: pred_amp = val;
      default:            pred_tau = val;
    endcase
  endtask

  // wait for the pipe to drain, then a little more
  task automatic drain();
    while (pending_samples.size() != 0 || expected_values.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 5) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
      3: return 32'h8000_0000 + $urandom_range(0, 3);
      4: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
    endcase
  endfunction

  task automatic queue_sample(logic [31:0] x, logic last);
    edf_in_t s;
    s.sample_x = x;
    s.last_point = last;
    pending_samples.push_back(s);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        expected_values.push_back(decay_value(in_data));
        void'(pending_samples.pop_front());
        send_gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (in_valid && !in_taken) begin
        // hold payload
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0 && !cfg_we) begin
        in_valid <= 1'b1;
        in_data <= pending_samples[0];
      end else begin
        in_valid <= 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          errors++;
          $display("unexpected result %h", out_data);
        end else begin
          edf_out_t e;
          e = expected_values.pop_front();
          if (out_data.model_value !== e.model_value)
            report_mismatch("model_value", out_data.model_value, e.model_value);
          if (out_data.overflow_flag !== e.overflow_flag)
            report_mismatch("overflow_flag", 32'(out_data.overflow_flag), 32'(e.overflow_flag));
          if (out_data.bad_tau_flag !== e.bad_tau_flag)
            report_mismatch("bad_tau_flag", 32'(out_data.bad_tau_flag), 32'(e.bad_tau_flag));
          if (out_data.last_out !== e.last_out)
            report_mismatch("last_out", 32'(out_data.last_out), 32'(e.last_out));
        end
        if ($urandom_range(0, 2) != 0) stall_left = $urandom_range(0, 14);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    pred_pos = RST_START_POSITION;
    pred_amp = RST_PEAK_AMPLITUDE;
    pred_tau = RST_DECAY_CONSTANT;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, field extremes, both markers
    queue_sample(32'h0, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b0);
    queue_sample(32'h8000_0000, 1'b1);
    queue_sample(32'hFFFF_FFFF, 1'b0);
    queue_sample(32'h0001_0000, 1'b0);
    queue_sample(32'hFFF0_0000, 1'b1);
    queue_sample(32'hFFC0_0000, 1'b0); // argument at the large limit
    queue_sample(32'hFFC0_0001, 1'b0);
    queue_sample(32'h0040_0000, 1'b1);
    drain();
    // zero tau
    write_reg(REG_DECAY_CONSTANT, 32'h0);
    queue_sample(32'h1234_5678, 1'b0);
    queue_sample(32'h8000_0000, 1'b1);
    drain();
    // zero amplitude with a huge exponent
    write_reg(REG_DECAY_CONSTANT, 32'h0000_0001);
    write_reg(REG_PEAK_AMPLITUDE, 32'h0);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b1);
    drain();
    // negative extreme amplitude and tau, then positive extremes
    write_reg(REG_PEAK_AMPLITUDE, 32'h8000_0000);
    write_reg(REG_DECAY_CONSTANT, 32'h8000_0000);
    write_reg(REG_START_POSITION, 32'h7FFF_FFFF);
    queue_sample(32'h7FFF_FFFF, 1'b0);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h0, 1'b1);
    drain();
    write_reg(REG_PEAK_AMPLITUDE, 32'h7FFF_FFFF);
    write_reg(REG_DECAY_CONSTANT, 32'h7FFF_FFFF);
    write_reg(REG_START_POSITION, 32'h8000_0000);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h0, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b1);
    drain();

    // random phases, each with its own settings
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_START_POSITION, rand_q16());
      write_reg(REG_PEAK_AMPLITUDE, ($urandom_range(0, 9) == 0) ? 32'h0 : rand_q16());
      write_reg(REG_DECAY_CONSTANT, ($urandom_range(0, 9) == 0) ? 32'h0 : rand_q16());
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 1) == 0)
          queue_sample(32'(pred_pos) + ($urandom_range(0, 1) ?
                       32'($signed(pred_tau) * ($signed($urandom_range(0, 128)) - 64) / 16)
                       : $urandom_range(0, 255)), 1'($urandom));
        else
          queue_sample(rand_q16(), 1'($urandom));
      end
      drain();
    end

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
